FILE: sv/framed_packet_parser_crc16_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the framed packet parser
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef FRAMED_PACKET_PARSER_CRC16_DEFINES_SVH
`define FRAMED_PACKET_PARSER_CRC16_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define FPPC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FPPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/fppc_pkg.sv
// ---------------------------------------------------------------------------
// fppc_pkg
// Shared constants and control structures of the framed packet parser.
// ---------------------------------------------------------------------------
package fppc_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
    localparam int LEN_W       = 7;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef logic [0:0] cfg_index_t;

    localparam cfg_index_t REG_SYNC_FIRST  = 1'b0;
    localparam cfg_index_t REG_SYNC_SECOND = 1'b1;

    localparam logic STATUS_GOOD = 1'b0;
    localparam logic STATUS_BAD  = 1'b1;

    typedef struct packed {
        logic init;
        logic start;
    } crc_ctl_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } mem_wr_t;

    typedef struct packed {
        logic             start;
        logic             status;
        logic [7:0]       kind;
        logic [LEN_W-1:0] len;
        logic [31:0]      good;
        logic [31:0]      bad;
    } emit_req_t;

endpackage

FILE: sv/fppc_crc_serial.sv
// ---------------------------------------------------------------------------
// fppc_crc_serial
// Bit-serial CRC-16 (poly 0x1021, MSB first): folds in a byte one bit at a time.
// ---------------------------------------------------------------------------
`include "framed_packet_parser_crc16_defines.svh"

module fppc_crc_serial
(
    input  logic               clk,
    input  logic               rst_n,
    input  fppc_pkg::crc_ctl_t ctl,
    input  logic [7:0]         din,
    output logic               busy,
    output logic [15:0]        crc
);
    import fppc_pkg::*;

    localparam logic [2:0] BIT_LAST = 3'd7;

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [7:0]  shift_reg;
    logic [7:0]  shift_next;
    logic [2:0]  cnt_reg;
    logic [2:0]  cnt_next;
    logic        busy_reg;
    logic        busy_next;
    logic        fb;

    always_comb
    begin
        crc_next   = crc_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        fb         = crc_reg[15] ^ shift_reg[7];
        if (ctl.init)
        begin
            crc_next = CRC_INIT;
        end
        if (ctl.start)
        begin
            shift_next = din;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            // advance one bit: shift out the top and fold in the polynomial
            crc_next   = {crc_reg[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
            shift_next = {shift_reg[6:0], 1'b0};
            cnt_next   = cnt_reg + 3'd1;
            if (cnt_reg == BIT_LAST)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= CRC_INIT;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            crc_reg  <= crc_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    assign busy = busy_reg;
    assign crc  = crc_reg;

    `FPPC_ASSERT_SAME(a_no_start_busy, ctl.start, !busy_reg, "CRC start while busy")
    `FPPC_ASSERT_NEXT(a_start_busy, ctl.start, busy_reg, "CRC not busy after start")
    `FPPC_ASSERT_NEXT(a_end_idle, busy_reg && cnt_reg == BIT_LAST && !ctl.start, !busy_reg,
        "CRC busy beyond eight bits")

endmodule

FILE: sv/fppc_emit.sv
// ---------------------------------------------------------------------------
// fppc_emit
// Payload store and result sequencer: replays a checked frame word by word.
// ---------------------------------------------------------------------------
`include "framed_packet_parser_crc16_defines.svh"

module fppc_emit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  fppc_pkg::emit_req_t          req,
    input  fppc_pkg::mem_wr_t            wr,
    output logic                         busy,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         status,
    output logic [7:0]                   frame_kind,
    output logic [fppc_pkg::LEN_W-1:0]   frame_len,
    output logic [fppc_pkg::ADDR_W-1:0]  byte_index,
    output logic [7:0]                   data_byte,
    output logic                         has_data,
    output logic                         last,
    output logic [31:0]                  good_count,
    output logic [31:0]                  error_count
);
    import fppc_pkg::*;

    localparam logic [1:0] E_IDLE = 2'd0;
    localparam logic [1:0] E_READ = 2'd1;
    localparam logic [1:0] E_SHOW = 2'd2;

    logic [7:0]        mem [MAX_PAYLOAD];
    logic [7:0]        rd_reg;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [ADDR_W-1:0] idx_reg;
    logic [ADDR_W-1:0] idx_next;
    logic              status_reg;
    logic              has_reg;
    logic [7:0]        kind_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [31:0]       good_reg;
    logic [31:0]       bad_reg;
    logic              load;
    logic              done;
    logic              last_c;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (state_reg == E_READ)
        begin
            rd_reg <= mem[idx_reg];
        end
    end

    assign load   = (state_reg == E_IDLE) && req.start;
    assign done   = out_valid && !out_stall;
    assign last_c = !has_reg || ({1'b0, idx_reg} + LEN_W'(1) == len_reg);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            E_IDLE:
            begin
                if (req.start)
                begin
                    idx_next   = '0;
                    state_next = (!req.status && req.len != '0) ? E_READ : E_SHOW;
                end
            end
            E_READ:
            begin
                state_next = E_SHOW;
            end
            E_SHOW:
            begin
                if (done)
                begin
                    if (last_c)
                    begin
                        state_next = E_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = E_READ;
                    end
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // hold the frame description for the whole replay
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= req.status;
            has_reg    <= !req.status && (req.len != '0);
            kind_reg   <= req.kind;
            len_reg    <= req.len;
            good_reg   <= req.good;
            bad_reg    <= req.bad;
        end
    end

    assign busy        = (state_reg != E_IDLE);
    assign out_valid   = (state_reg == E_SHOW);
    assign status      = status_reg;
    assign frame_kind  = kind_reg;
    assign frame_len   = len_reg;
    assign byte_index  = idx_reg;
    assign data_byte   = has_reg ? rd_reg : 8'h00;
    assign has_data    = has_reg;
    assign last        = last_c;
    assign good_count  = good_reg;
    assign error_count = bad_reg;

    `FPPC_ASSERT_SAME(a_start_idle, req.start, state_reg == E_IDLE, "replay started while busy")
    `FPPC_ASSERT_SAME(a_empty_last, out_valid && !has_data, last,
        "result without data not marked last")
    `FPPC_ASSERT_NEXT(a_last_idle, out_valid && !out_stall && last, state_reg == E_IDLE,
        "replay continues after last word")

endmodule

FILE: sv/framed_packet_parser_crc16.sv
// ---------------------------------------------------------------------------
// framed_packet_parser_crc16
// Sync-framed packet deframer with CRC-16/CCITT-FALSE check and replay.
// ---------------------------------------------------------------------------
//  channel   direction  handshake               word
//  input     in         in_valid / in_stall     rx_byte
//  output    out        out_valid / out_stall   status .. error_count
//  config    in         cfg_we                  cfg_index, cfg_data
//
//  Sync, CRC-low and oversized length bytes are taken without a stall; kind,
//  length and payload bytes stall the input while the CRC unit takes eight
//  bit steps. The CRC-high byte starts the replay, which stalls the input:
//  payload results are read, then shown; error or empty results only shown.
//  Reset sets sync bytes to 0xA5/0x5A, hunting phase, CRC 0xFFFF and zero
//  counters; the payload memory is not cleared.
//  out_stall holds the current result; in_stall stays high until it is taken.
// ---------------------------------------------------------------------------
module framed_packet_parser_crc16
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  fppc_pkg::cfg_index_t         cfg_index,
    input  logic [7:0]                   cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   rx_byte,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         status,
    output logic [7:0]                   frame_kind,
    output logic [fppc_pkg::LEN_W-1:0]   frame_len,
    output logic [fppc_pkg::ADDR_W-1:0]  byte_index,
    output logic [7:0]                   data_byte,
    output logic                         has_data,
    output logic                         last,
    output logic [31:0]                  good_count,
    output logic [31:0]                  error_count
);
    import fppc_pkg::*;

    localparam logic [2:0] PH_HUNT1 = 3'd0;
    localparam logic [2:0] PH_HUNT2 = 3'd1;
    localparam logic [2:0] PH_KIND  = 3'd2;
    localparam logic [2:0] PH_LEN   = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_CRCLO = 3'd5;
    localparam logic [2:0] PH_CRCHI = 3'd6;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'hA5;
    localparam logic [7:0] SYNC_SECOND_RST = 8'h5A;

    logic [7:0]       sync_first_reg;
    logic [7:0]       sync_second_reg;
    logic [2:0]       phase_reg;
    logic [2:0]       phase_next;
    logic [7:0]       kind_reg;
    logic [7:0]       kind_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [LEN_W-1:0] count_reg;
    logic [LEN_W-1:0] count_next;
    logic [7:0]       crc_lo_reg;
    logic [7:0]       crc_lo_next;
    logic [31:0]      good_reg;
    logic [31:0]      good_next;
    logic [31:0]      bad_reg;
    logic [31:0]      bad_next;

    logic             accept;
    logic             crc_busy;
    logic [15:0]      crc_value;
    logic             emit_busy;
    crc_ctl_t         crc_ctl;
    mem_wr_t          wr;
    emit_req_t        req;

    assign in_stall = crc_busy | emit_busy;
    assign accept   = in_valid & !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                REG_SYNC_SECOND: sync_second_reg <= cfg_data;
                default:         sync_first_reg  <= sync_first_reg;
            endcase
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        crc_lo_next = crc_lo_reg;
        good_next   = good_reg;
        bad_next    = bad_reg;
        crc_ctl     = '0;
        wr.en       = 1'b0;
        wr.addr     = count_reg[ADDR_W-1:0];
        wr.data     = rx_byte;
        req.start   = 1'b0;
        req.status  = STATUS_GOOD;
        req.kind    = kind_reg;
        req.len     = len_reg;
        req.good    = good_reg;
        req.bad     = bad_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT1:
                begin
                    if (rx_byte == sync_first_reg)
                    begin
                        phase_next = PH_HUNT2;
                    end
                end
                PH_HUNT2:
                begin
                    // a repeated first sync byte keeps waiting
                    if (rx_byte == sync_second_reg)
                    begin
                        phase_next   = PH_KIND;
                        crc_ctl.init = 1'b1;
                    end
                    else if (rx_byte != sync_first_reg)
                    begin
                        phase_next = PH_HUNT1;
                    end
                end
                PH_KIND:
                begin
                    kind_next     = rx_byte;
                    crc_ctl.start = 1'b1;
                    phase_next    = PH_LEN;
                end
                PH_LEN:
                begin
                    if (rx_byte > 8'(MAX_PAYLOAD))
                    begin
                        phase_next = PH_HUNT1;
                    end
                    else
                    begin
                        len_next      = rx_byte[LEN_W-1:0];
                        count_next    = '0;
                        crc_ctl.start = 1'b1;
                        phase_next    = (rx_byte == 8'h00) ? PH_CRCLO : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    wr.en         = 1'b1;
                    crc_ctl.start = 1'b1;
                    count_next    = count_reg + LEN_W'(1);
                    if (count_next >= len_reg)
                    begin
                        phase_next = PH_CRCLO;
                    end
                end
                PH_CRCLO:
                begin
                    crc_lo_next = rx_byte;
                    phase_next  = PH_CRCHI;
                end
                PH_CRCHI:
                begin
                    phase_next = PH_HUNT1;
                    req.start  = 1'b1;
                    if ({rx_byte, crc_lo_reg} != crc_value)
                    begin
                        bad_next   = bad_reg + 32'd1;
                        req.status = STATUS_BAD;
                    end
                    else
                    begin
                        good_next = good_reg + 32'd1;
                    end
                    req.good = good_next;
                    req.bad  = bad_next;
                end
                default:
                begin
                    phase_next = PH_HUNT1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT1;
            kind_reg   <= '0;
            len_reg    <= '0;
            count_reg  <= '0;
            crc_lo_reg <= '0;
            good_reg   <= '0;
            bad_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            len_reg    <= len_next;
            count_reg  <= count_next;
            crc_lo_reg <= crc_lo_next;
            good_reg   <= good_next;
            bad_reg    <= bad_next;
        end
    end

    fppc_crc_serial u_crc
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (crc_ctl),
        .din   (rx_byte),
        .busy  (crc_busy),
        .crc   (crc_value)
    );

    fppc_emit u_emit
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .wr          (wr),
        .busy        (emit_busy),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .frame_kind  (frame_kind),
        .frame_len   (frame_len),
        .byte_index  (byte_index),
        .data_byte   (data_byte),
        .has_data    (has_data),
        .last        (last),
        .good_count  (good_count),
        .error_count (error_count)
    );

endmodule
